// ===== hw/rtl/tab_expand_trailing_space_strip_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the tab expand and trailing space strip block
// Both macros sample on clk_i and are disabled while rst_ni is low
// ----------------------------------------------------------------------------
`ifndef TAB_EXPAND_TRAILING_SPACE_STRIP_MACROS_SVH
`define TAB_EXPAND_TRAILING_SPACE_STRIP_MACROS_SVH

// expression holds at every sampled edge
`define TES_ASSERT_HOLD(lbl, expr) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (expr)) \
    else $error("assertion failed");

// antecedent implies consequent at the next edge
`define TES_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== hw/rtl/tes_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tes_pkg
// Types and constants shared by the tab expand and trailing space strip block
// ----------------------------------------------------------------------------
package tes_pkg;

  localparam int MaxPending = 4095;
  localparam int CountW     = 12;
  localparam int FieldMax   = 4095;

  localparam logic [CountW-1:0] PendCap =
    (MaxPending > FieldMax) ? CountW'(FieldMax) : CountW'(MaxPending);

  localparam logic [7:0] ChNl  = 8'h0A;
  localparam logic [7:0] ChTab = 8'h09;
  localparam logic [7:0] ChSp  = 8'h20;

  typedef struct packed {
    logic [1:0]        phase;
    logic [CountW-1:0] pending;
    logic              sat;
  } state_t;

  typedef struct packed {
    logic [CountW-1:0] spaces;
    logic [7:0]        data;
    logic              has_byte;
    logic              last;
    logic              ovf;
  } result_t;

endpackage

// ===== hw/rtl/tes_step.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tes_step
// Next state and result for one item: space counting, tab stops, flushes
// ----------------------------------------------------------------------------
module tes_step
  import tes_pkg::*;
(
  input  state_t     state_i,
  input  logic [7:0] data_i,
  input  logic       eos_i,
  output state_t     state_o,
  output result_t    result_o,
  output logic       produce_o
);

  logic [2:0]        add_n;
  logic [CountW:0]   sum;
  logic [CountW-1:0] sat_count;
  logic              sat_hit;

  assign add_n     = (data_i == ChTab) ? (3'd4 - {1'b0, state_i.phase}) : 3'd1;
  assign sum       = {1'b0, state_i.pending} + (CountW + 1)'(add_n);
  assign sat_hit   = sum > {1'b0, PendCap};
  assign sat_count = sat_hit ? PendCap : sum[CountW-1:0];

  always_comb begin
    state_o   = state_i;
    result_o  = '0;
    produce_o = 1'b0;
    if (eos_i) begin
      produce_o       = 1'b1;
      result_o.last   = 1'b1;
      if (state_i.pending != '0) begin
        result_o.data     = ChNl;
        result_o.has_byte = 1'b1;
      end
      state_o = '0;
    end else begin
      unique case (data_i)
        ChNl: begin
          produce_o         = 1'b1;
          result_o.data     = ChNl;
          result_o.has_byte = 1'b1;
          state_o           = '0;
        end
        ChSp: begin
          state_o.pending = sat_count;
          state_o.sat     = state_i.sat | sat_hit;
          state_o.phase   = state_i.phase + 2'd1;
        end
        ChTab: begin
          state_o.pending = sat_count;
          state_o.sat     = state_i.sat | sat_hit;
          state_o.phase   = 2'd0;
        end
        default: begin
          produce_o         = 1'b1;
          result_o.spaces   = state_i.pending;
          result_o.data     = data_i;
          result_o.has_byte = 1'b1;
          result_o.ovf      = state_i.sat;
          state_o.pending   = '0;
          state_o.sat       = 1'b0;
          state_o.phase     = state_i.phase + 2'd1;
        end
      endcase
    end
  end

endmodule

// ===== hw/rtl/tab_expand_trailing_space_strip.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tab_expand_trailing_space_strip
// Expands tabs to 4-column stops, holds spaces back as a count, drops them
// before a newline and turns them into a newline at end of stream
//
//   channel  handshake             payload
//   in       in_valid_i/in_stall_o text_byte_i, end_of_stream_i
//   out      out_valid_o/out_stall_i spaces_before_o, out_byte_o, has_byte_o,
//                                  is_last_o, count_overflow_o
//
// one item per cycle unless a held result stalls it; a result passes the input
// register and the result register, with one state update per item between them
// rst_ni clears valids and the column, count and saturation state at once
// a held result stalls only items that make a result; spaces and tabs
// still pass through while the output is stalled
// ----------------------------------------------------------------------------
`include "tab_expand_trailing_space_strip_macros.svh"

module tab_expand_trailing_space_strip
  import tes_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [7:0]        text_byte_i,
  input  logic              end_of_stream_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [CountW-1:0] spaces_before_o,
  output logic [7:0]        out_byte_o,
  output logic              has_byte_o,
  output logic              is_last_o,
  output logic              count_overflow_o
);

  logic       in_valid_q, in_valid_d;
  logic [7:0] in_byte_q;
  logic       in_eos_q;
  state_t     state_q, state_d, step_state;
  result_t    result_q, step_result;
  logic       out_valid_q, out_valid_d;
  logic       produce, out_free, advance, in_take;

  tes_step u_step (
    .state_i   (state_q),
    .data_i    (in_byte_q),
    .eos_i     (in_eos_q),
    .state_o   (step_state),
    .result_o  (step_result),
    .produce_o (produce)
  );

  assign out_free   = !out_valid_q || !out_stall_i;
  assign advance    = in_valid_q && (!produce || out_free);
  assign in_stall_o = in_valid_q && !advance;
  assign in_take    = in_valid_i && !in_stall_o;

  always_comb begin
    in_valid_d = in_take | (in_valid_q & ~advance);
    state_d    = advance ? step_state : state_q;
    if (advance && produce) begin
      out_valid_d = 1'b1;
    end else begin
      out_valid_d = out_free ? 1'b0 : out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      state_q     <= '0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
      state_q     <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_byte_q <= text_byte_i;
      in_eos_q  <= end_of_stream_i;
    end
    if (advance && produce) begin
      result_q <= step_result;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign spaces_before_o  = result_q.spaces;
  assign out_byte_o       = result_q.data;
  assign has_byte_o       = result_q.has_byte;
  assign is_last_o        = result_q.last;
  assign count_overflow_o = result_q.ovf;

  // input side blocks only behind a held result
  `TES_ASSERT_HOLD(a_stall_cause, !in_stall_o || (out_valid_q && out_stall_i))
  // count never passes its cap
  `TES_ASSERT_HOLD(a_pending_cap, state_q.pending <= PendCap)
  // end of stream leaves the state cleared
  `TES_ASSERT_NEXT(a_eos_clear, advance && in_eos_q, state_q == '0)
  // overflow only reported on an ordinary emitted byte
  `TES_ASSERT_HOLD(a_ovf_byte,
    !(out_valid_q && result_q.ovf) || (result_q.has_byte && !result_q.last))

endmodule

// ===== verif/tab_expand_trailing_space_strip_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tab_expand_trailing_space_strip_tb
// Drives byte streams into the tab expand and trailing space strip block and
// checks every result against a cycle-free model of the text cleaner kept in
// the bench: tab stops from each column, dropped trailing spaces, saturation
// of the held space count, end of stream with and without held spaces, long
// output back-pressure and random text with random idling on both sides
// ----------------------------------------------------------------------------
module tab_expand_trailing_space_strip_tb;
  import tes_pkg::*;

  localparam int BurstMax   = 19;
  localparam int HoldCycles = 250;
  localparam int TabsToCap  = 1023;

  logic              clk_i;
  logic              rst_ni;
  logic              in_valid_i;
  logic              in_stall_o;
  logic [7:0]        text_byte_i;
  logic              end_of_stream_i;
  logic              out_valid_o;
  logic              out_stall_i;
  logic [CountW-1:0] spaces_before_o;
  logic [7:0]        out_byte_o;
  logic              has_byte_o;
  logic              is_last_o;
  logic              count_overflow_o;

  // model state of the cleaner
  logic [1:0]        col_phase;
  logic [CountW-1:0] held_spaces;
  logic              held_sat;

  result_t cleaned_q[$];
  result_t got_res;
  result_t want_res;

  bit idle_on;
  bit hold_req;
  int errors;
  int items_sent;
  int results_seen;
  int ovf_seen;
  int last_seen;
  int hold_count;

  tab_expand_trailing_space_strip u_top (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .text_byte_i      (text_byte_i),
    .end_of_stream_i  (end_of_stream_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .spaces_before_o  (spaces_before_o),
    .out_byte_o       (out_byte_o),
    .has_byte_o       (has_byte_o),
    .is_last_o        (is_last_o),
    .count_overflow_o (count_overflow_o)
  );

  initial clk_i = 1'b0;
  always #6 clk_i = ~clk_i;

  initial begin
    #10_000_000;
    $display("FAIL");
    $finish;
  end

  task automatic push_cleaned(input logic [CountW-1:0] spaces, input logic [7:0] data,
                              input logic has, input logic last, input logic ovf);
    result_t r;
    r.spaces   = spaces;
    r.data     = data;
    r.has_byte = has;
    r.last     = last;
    r.ovf      = ovf;
    cleaned_q.push_back(r);
  endtask

  task automatic hold_back(input int n);
    int sum;
    sum = int'(held_spaces) + n;
    if (sum > int'(PendCap)) begin
      held_spaces = PendCap;
      held_sat    = 1'b1;
    end else begin
      held_spaces = CountW'(sum);
    end
  endtask

  task automatic clean_byte(input logic [7:0] b, input logic eos);
    if (eos) begin
      if (held_spaces != '0) push_cleaned('0, ChNl, 1'b1, 1'b1, 1'b0);
      else push_cleaned('0, 8'h00, 1'b0, 1'b1, 1'b0);
      col_phase   = '0;
      held_spaces = '0;
      held_sat    = 1'b0;
    end else if (b == ChNl) begin
      push_cleaned('0, ChNl, 1'b1, 1'b0, 1'b0);
      col_phase   = '0;
      held_spaces = '0;
      held_sat    = 1'b0;
    end else if (b == ChSp) begin
      hold_back(1);
      col_phase = col_phase + 2'd1;
    end else if (b == ChTab) begin
      hold_back(4 - int'(col_phase));
      col_phase = '0;
    end else begin
      push_cleaned(held_spaces, b, 1'b1, 1'b0, held_sat);
      held_spaces = '0;
      held_sat    = 1'b0;
      col_phase   = col_phase + 2'd1;
    end
  endtask

  // entered and left at a falling edge
  task automatic send_item(input logic [7:0] b, input logic eos);
    int gap;
    if (idle_on && $urandom_range(0, 7) == 0) begin
      gap = $urandom_range(1, BurstMax);
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i      <= 1'b1;
    text_byte_i     <= b;
    end_of_stream_i <= eos;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    clean_byte(b, eos);
    items_sent++;
    @(negedge clk_i);
  endtask

  task automatic note_failure(input string what);
    errors++;
    if (errors <= 10) begin
      $display("%0t %s: exp spaces=%0d byte=%02h has=%0b last=%0b ovf=%0b", $realtime, what,
               want_res.spaces, want_res.data, want_res.has_byte, want_res.last, want_res.ovf);
      $display("%0t %s: got spaces=%0d byte=%02h has=%0b last=%0b ovf=%0b", $realtime, what,
               got_res.spaces, got_res.data, got_res.has_byte, got_res.last, got_res.ovf);
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got_res.spaces   = spaces_before_o;
      got_res.data     = out_byte_o;
      got_res.has_byte = has_byte_o;
      got_res.last     = is_last_o;
      got_res.ovf      = count_overflow_o;
      results_seen++;
      if (count_overflow_o) ovf_seen++;
      if (is_last_o) last_seen++;
      if (cleaned_q.size() == 0) begin
        want_res = '0;
        note_failure("unexpected item");
      end else begin
        want_res = cleaned_q.pop_front();
        if (got_res.spaces !== want_res.spaces || got_res.data !== want_res.data ||
            got_res.has_byte !== want_res.has_byte || got_res.last !== want_res.last ||
            got_res.ovf !== want_res.ovf)
          note_failure("mismatch");
      end
    end
  end

  // output side: random stall bursts, plus one long hold-off on request
  initial begin
    out_stall_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall_i <= 1'b1;
        hold_count = 0;
        while (hold_count < HoldCycles) begin
          @(negedge clk_i);
          hold_count++;
        end
        out_stall_i <= 1'b0;
      end else if (idle_on && $urandom_range(0, 9) == 0) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, BurstMax)) @(negedge clk_i);
        out_stall_i <= 1'b0;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  function automatic logic [7:0] random_text_byte();
    int r;
    r = $urandom_range(0, 99);
    if (r < 30) return ChSp;
    if (r < 45) return ChTab;
    if (r < 55) return ChNl;
    if (r < 63) return 8'($urandom_range(0, 255));
    return 8'($urandom_range(8'h21, 8'h7e));
  endfunction

  task automatic run_extreme_bytes();
    send_item(8'h00, 1'b0);
    send_item(8'hff, 1'b0);
    send_item(8'h80, 1'b0);
    send_item(8'h7f, 1'b0);
    send_item(ChNl, 1'b0);
    send_item(ChSp, 1'b0);
    send_item(8'h01, 1'b0);
    send_item(ChSp, 1'b0);
    send_item(ChSp, 1'b0);
    send_item(ChNl, 1'b0);
    send_item(ChSp, 1'b0);
    send_item(8'h0d, 1'b0);
    send_item(ChNl, 1'b0);
  endtask

  task automatic run_tab_stops();
    for (int k = 0; k < 4; k++) begin
      send_item(ChNl, 1'b0);
      repeat (k) send_item("a", 1'b0);
      send_item(ChTab, 1'b0);
      send_item("b", 1'b0);
    end
    send_item(ChSp, 1'b0);
    send_item(ChTab, 1'b0);
    send_item(ChTab, 1'b0);
    send_item("c", 1'b0);
  endtask

  task automatic run_end_of_stream();
    send_item(8'h00, 1'b1);
    send_item("a", 1'b0);
    send_item(ChSp, 1'b0);
    send_item(8'hff, 1'b1);
    send_item(ChNl, 1'b1);
    send_item(ChSp, 1'b0);
    send_item(ChTab, 1'b0);
    send_item(ChSp, 1'b1);
    send_item(ChTab, 1'b0);
    send_item("d", 1'b0);
  endtask

  task automatic fill_to_cap(input int extra_spaces);
    send_item(ChNl, 1'b0);
    repeat (TabsToCap) send_item(ChTab, 1'b0);
    repeat (extra_spaces) send_item(ChSp, 1'b0);
  endtask

  task automatic run_saturation();
    fill_to_cap(6);
    send_item("f", 1'b0);
    send_item(ChSp, 1'b0);
    send_item("g", 1'b0);
  endtask

  task automatic run_backpressure();
    hold_req = 1'b1;
    for (int i = 0; i < 80; i++) begin
      if (i % 5 == 4) send_item(ChSp, 1'b0);
      else send_item(8'($urandom_range(8'h41, 8'h5a)), 1'b0);
    end
    send_item(ChNl, 1'b0);
  endtask

  task automatic run_random_text(input int n);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 99) < 3) send_item(8'($urandom_range(0, 255)), 1'b1);
      else send_item(random_text_byte(), 1'b0);
    end
  endtask

  task automatic drain();
    int waited;
    in_valid_i <= 1'b0;
    waited = 0;
    while (cleaned_q.size() != 0 && waited < 20000) begin
      @(negedge clk_i);
      waited++;
    end
    repeat (8) @(negedge clk_i);
    if (cleaned_q.size() != 0) begin
      errors += cleaned_q.size();
      $display("%0d expected items never arrived", cleaned_q.size());
    end
  endtask

  initial begin
    rst_ni          = 1'b0;
    in_valid_i      = 1'b0;
    text_byte_i     = 8'h00;
    end_of_stream_i = 1'b0;
    idle_on         = 1'b1;
    hold_req        = 1'b0;
    errors          = 0;
    items_sent      = 0;
    results_seen    = 0;
    ovf_seen        = 0;
    last_seen       = 0;
    col_phase       = '0;
    held_spaces     = '0;
    held_sat        = 1'b0;
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    run_extreme_bytes();
    run_tab_stops();
    run_end_of_stream();
    run_saturation();
    run_backpressure();
    run_random_text(650);
    idle_on = 1'b0;
    run_random_text(200);
    drain();

    $display("sent %0d bytes and end marks, checked %0d results", items_sent, results_seen);
    $display("%0d with saturated count, %0d end of stream, hold-off %0d cycles",
             ovf_seen, last_seen, hold_count);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
